/* hdl/sfp_pkg.sv */
// Shared types, constants and the word layout table for the sensor frame parser.
// Used by every file of the block but sfp_ram; depends on nothing.
package sfp_pkg;

  // Payload store depth and its address width
  localparam int PayloadBytes = 36;
  localparam int AddrW        = $clog2(PayloadBytes);

  // Result words of a good frame
  localparam int NumWords = 17;
  localparam int WordIdW  = 5;
  localparam logic [WordIdW-1:0] LastId = WordIdW'(NumWords - 1);

  // Frame constants
  localparam logic [7:0]  StartByte0 = 8'h42;
  localparam logic [7:0]  StartByte1 = 8'h4D;
  localparam logic [15:0] LenShort   = 16'(2 * 9 + 2);
  localparam logic [15:0] LenMid     = 16'(2 * 13 + 2);
  localparam logic [15:0] LenLong    = 16'(2 * 18 + 2);

  typedef enum logic [1:0] {
    ERR_FIRST    = 2'd0,
    ERR_SECOND   = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_code_t;

  // Controller to datapath
  typedef struct packed {
    logic               take;
    logic               load_word;
    logic [WordIdW-1:0] word_id;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic err;
    logic frame_good;
  } dp_status_t;

  typedef struct packed {
    logic             used;
    logic [AddrW-1:0] offset;
  } word_sel_t;

  // Byte offset of the high byte of word id in the chosen layout
  function automatic word_sel_t word_select(logic full, logic [WordIdW-1:0] id);
    word_sel_t s;
    s.used   = 1'b1;
    s.offset = '0;
    if (full) begin
      unique case (id)
        5'd13:   s.offset = AddrW'(6'd27);
        5'd14:   s.offset = AddrW'(6'd30);
        5'd15:   s.offset = AddrW'(6'd32);
        5'd16:   s.offset = AddrW'(6'd34);
        default: s.offset = AddrW'({id, 1'b0});
      endcase
    end else begin
      unique case (id)
        5'd1:    s.offset = AddrW'(6'd0);
        5'd12:   s.offset = AddrW'(6'd2);
        5'd13:   s.offset = AddrW'(6'd5);
        5'd14:   s.offset = AddrW'(6'd8);
        5'd15:   s.offset = AddrW'(6'd10);
        5'd16:   s.offset = AddrW'(6'd12);
        default: s.used   = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

/* hdl/sfp_if.sv */
// Request channels of the sensor frame parser: byte input and result output.
// Depends on sfp_pkg for the field widths.
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_error;
  logic [1:0]                  error_code;
  logic [sfp_pkg::WordIdW-1:0] field_id;
  logic [15:0]                 value;
  logic                        last;
  modport source (output valid, output is_error, output error_code, output field_id,
                  output value, output last, input ready);
  modport sink   (input valid, input is_error, input error_code, input field_id,
                  input value, input last, output ready);
endinterface

/* hdl/sfp_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module sfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  output logic [Width-1:0]         rdata_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hdl/sfp_ctrl.sv */
// Sequencer of the sensor frame parser: accepts requests and walks the result words.
// Depends on sfp_pkg.
module sfp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfp_pkg::dp_status_t status,
  output sfp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_LOAD  = 3'b100
  } state_t;

  state_t                      state, state_next;
  logic [sfp_pkg::WordIdW-1:0] word_id;

  assign in_ready      = (state == S_IDLE) && status.out_free;
  assign cmd.take      = in_valid && in_ready;
  assign cmd.load_word = (state == S_LOAD) && status.out_free;
  assign cmd.word_id   = word_id;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd.take && status.frame_good) state_next = S_FETCH;
      S_FETCH: state_next = S_LOAD;
      S_LOAD: begin
        if (cmd.load_word) begin
          state_next = (word_id == sfp_pkg::LastId) ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      word_id <= '0;
    end else begin
      state <= state_next;
      if (cmd.take && status.frame_good) begin
        word_id <= '0;
      end else if (cmd.load_word) begin
        word_id <= word_id + 1'b1;
      end
    end
  end

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.frame_good) |=> (state == S_FETCH && word_id == '0))
    else $error("burst did not start at word zero");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_word && word_id == sfp_pkg::LastId) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the last word");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (word_id <= sfp_pkg::LastId))
    else $error("word index beyond the layout");

endmodule

/* hdl/sfp_datapath.sv */
// Datapath of the sensor frame parser: framing registers, checksum, payload store
// and output register. Depends on sfp_pkg and sfp_ram.
module sfp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        read_mode_we,
  input  logic                        read_mode_wdata,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_rx_byte,
  input  sfp_pkg::dp_cmd_t            cmd,
  output sfp_pkg::dp_status_t         status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        is_error,
  output logic [1:0]                  error_code,
  output logic [sfp_pkg::WordIdW-1:0] field_id,
  output logic [15:0]                 value,
  output logic                        last
);

  localparam int AddrW = sfp_pkg::AddrW;

  logic                      read_mode;
  logic                      sticky;
  logic [5:0]                pos;
  logic [15:0]               sum;
  logic [7:0]                len_hi;
  logic [5:0]                frame_len;
  logic [7:0]                chk_hi;
  logic [sfp_pkg::PayloadBytes-1:0] valid_bits;

  logic [5:0]                pos_next;
  logic [15:0]               sum_next;
  logic [7:0]                len_hi_next;
  logic [5:0]                frame_len_next;
  logic [7:0]                chk_hi_next;
  logic                      err_raw;
  logic                      good_raw;
  logic                      store_raw;
  sfp_pkg::err_code_t        err_code;
  logic [15:0]               len_full;
  logic [5:0]                pay_idx;
  logic [6:0]                pos_ext;
  logic [6:0]                len_ext;
  logic                      byte_live;
  logic                      mem_we;

  sfp_pkg::word_sel_t        sel;
  logic [AddrW-1:0]          raddr_a;
  logic [AddrW-1:0]          raddr_b;
  logic [7:0]                rdata_a;
  logic [7:0]                rdata_b;
  logic                      hi_valid;
  logic                      lo_valid;
  logic [15:0]               word_value;

  assign len_full = {len_hi, in_rx_byte};
  assign pay_idx  = pos - 6'd4;
  assign pos_ext  = {1'b0, pos};
  assign len_ext  = {1'b0, frame_len};

  // Decode one received byte against the current framing position
  always_comb begin
    pos_next       = pos + 6'd1;
    sum_next       = sum;
    len_hi_next    = len_hi;
    frame_len_next = frame_len;
    chk_hi_next    = chk_hi;
    err_raw        = 1'b0;
    good_raw       = 1'b0;
    store_raw      = 1'b0;
    err_code       = sfp_pkg::ERR_FIRST;
    priority if (pos == 6'd0) begin
      err_raw  = (in_rx_byte != sfp_pkg::StartByte0);
      err_code = sfp_pkg::ERR_FIRST;
      sum_next = {8'd0, in_rx_byte};
    end else if (pos == 6'd1) begin
      err_raw  = (in_rx_byte != sfp_pkg::StartByte1);
      err_code = sfp_pkg::ERR_SECOND;
      sum_next = sum + {8'd0, in_rx_byte};
    end else if (pos == 6'd2) begin
      sum_next    = sum + {8'd0, in_rx_byte};
      len_hi_next = in_rx_byte;
    end else if (pos == 6'd3) begin
      err_raw = !((len_full == sfp_pkg::LenShort) || (len_full == sfp_pkg::LenMid) ||
                  (len_full == sfp_pkg::LenLong));
      err_code       = sfp_pkg::ERR_LENGTH;
      sum_next       = sum + {8'd0, in_rx_byte};
      frame_len_next = in_rx_byte[5:0];
    end else if (pos_ext == len_ext + 7'd2) begin
      chk_hi_next = in_rx_byte;
    end else if (pos_ext == len_ext + 7'd3) begin
      pos_next = '0;
      err_code = sfp_pkg::ERR_CHECKSUM;
      err_raw  = ({chk_hi, in_rx_byte} != sum);
      good_raw = !err_raw;
    end else begin
      sum_next  = sum + {8'd0, in_rx_byte};
      store_raw = ({1'b0, pay_idx} < 7'(sfp_pkg::PayloadBytes));
    end
  end

  assign byte_live         = !in_opcode && !sticky;
  assign status.err        = byte_live && err_raw;
  assign status.frame_good = byte_live && good_raw;
  assign status.out_free   = !out_valid || out_ready;
  assign mem_we            = cmd.take && byte_live && store_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_mode  <= 1'b0;
      sticky     <= 1'b0;
      pos        <= '0;
      sum        <= '0;
      len_hi     <= '0;
      frame_len  <= '0;
      chk_hi     <= '0;
      valid_bits <= '0;
    end else begin
      if (read_mode_we) begin
        read_mode <= read_mode_wdata;
      end
      if (cmd.take) begin
        if (in_opcode) begin
          sticky <= 1'b0;
          pos    <= '0;
        end else if (!sticky) begin
          if (err_raw) begin
            sticky <= 1'b1;
            pos    <= '0;
          end else begin
            pos       <= pos_next;
            sum       <= sum_next;
            len_hi    <= len_hi_next;
            frame_len <= frame_len_next;
            chk_hi    <= chk_hi_next;
          end
        end
      end
      if (mem_we) begin
        valid_bits[pay_idx[AddrW-1:0]] <= 1'b1;
      end
    end
  end

  // Word readout: both bytes of a word in one read
  assign sel     = sfp_pkg::word_select(read_mode, cmd.word_id);
  assign raddr_a = sel.offset;
  assign raddr_b = sel.offset + 1'b1;

  sfp_ram #(
    .Width (8),
    .Depth (sfp_pkg::PayloadBytes)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (pay_idx[AddrW-1:0]),
    .wdata   (in_rx_byte),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Track whether each byte read was ever written; unwritten bytes read as zero
  always_ff @(posedge clk) begin
    hi_valid <= valid_bits[raddr_a];
    lo_valid <= valid_bits[raddr_b];
  end

  assign word_value = sel.used ? {rdata_a & {8{hi_valid}}, rdata_b & {8{lo_valid}}} : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.take && status.err) || cmd.load_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.err) begin
      is_error   <= 1'b1;
      error_code <= err_code;
      field_id   <= '0;
      value      <= '0;
      last       <= 1'b1;
    end else if (cmd.load_word) begin
      is_error   <= 1'b0;
      error_code <= sfp_pkg::ERR_FIRST;
      field_id   <= cmd.word_id;
      value      <= word_value;
      last       <= (cmd.word_id == sfp_pkg::LastId);
    end
  end

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.err) |=> (sticky && out_valid && is_error && last))
    else $error("error request did not raise sticky error and result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(field_id)))
    else $error("pending result overwritten");

endmodule

/* hdl/sensor_frame_parser.sv */
// Sensor frame parser: validates received frames and bursts out the measurement words.
// Top level; depends on sfp_pkg, sfp_if, sfp_ctrl and sfp_datapath.
// Errors: an error result is presented in the cycle after the byte that causes it.
// Throughput: one byte request per cycle while the output register is free and no
//   burst runs; the closing checksum byte of a good frame starts a burst of 17 words,
//   each a store read then an output load, and no byte is taken until the burst ends.
// Reset (rst, synchronous, active high): clears the sequencer, sticky error, framing,
//   checksum and read_mode, and the per-byte written flags so the store reads as zero.
module sensor_frame_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  sfp_in_if.sink           in_ch,
  sfp_out_if.source        out_ch
);

  sfp_pkg::dp_cmd_t    cmd;
  sfp_pkg::dp_status_t status;

  // Sequencer: takes byte and clear requests, then walks word ids for a good frame
  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: frame checks, running sum, payload store and the result register
  sfp_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .read_mode_we    (cfg_we),
    .read_mode_wdata (cfg_wdata),
    .in_opcode       (in_ch.opcode),
    .in_rx_byte      (in_ch.rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .is_error        (out_ch.is_error),
    .error_code      (out_ch.error_code),
    .field_id        (out_ch.field_id),
    .value           (out_ch.value),
    .last            (out_ch.last)
  );

endmodule

/* sim/sensor_frame_parser_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sensor_frame_parser: byte requests in, measurement words out.
// Depends on sfp_pkg, the sfp_in_if / sfp_out_if channels and the sensor_frame_parser RTL.
module sensor_frame_parser_tb;

  // Request opcodes on the byte channel
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Shapes of the random byte sequences
  typedef enum int {
    SEQ_GOOD,
    SEQ_BAD_SUM,
    SEQ_BAD_START,
    SEQ_BAD_SECOND,
    SEQ_BAD_LENGTH,
    SEQ_CUT
  } seq_kind_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct packed {
    logic                        is_error;
    sfp_pkg::err_code_t          error_code;
    logic [sfp_pkg::WordIdW-1:0] field_id;
    logic [15:0]                 value;
    logic                        last;
  } frame_result_t;

  localparam int IdlePct     = 35;   // chance of an idle cycle on either side
  localparam int DrainCycles = 40;   // lets a 17-word burst drain
  localparam int StallLimit  = 1000; // cycles with no request moving on any channel
  localparam int RandomItems = 60;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic sink_ready = 1'b0;
  bit   steady = 1'b0;               // suppress idling on both sides

  sfp_in_if  in_ch ();
  sfp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  sensor_frame_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame tracker: our own copy of the parser state, advanced once per accepted
  // request. It queues the results that each request should produce.
  // ---------------------------------------------------------------------------
  logic        full_layout;
  logic        err_hold;
  logic [5:0]  frame_pos;
  logic [15:0] sum_run;
  logic [15:0] len_seen;
  logic [7:0]  sum_high;
  logic [7:0]  payload_copy [sfp_pkg::PayloadBytes];

  frame_result_t awaited_results [$];

  int live_items;   // requests the parser acted on (ignored bytes excluded)
  int total_items;
  int good_frames;
  int error_results;
  int checked;
  int mode_writes;
  int failures;

  function automatic string show_result(frame_result_t r);
    return $sformatf("is_error=%0b error_code=%0d field_id=%0d value=%h last=%0b",
                     r.is_error, r.error_code, r.field_id, r.value, r.last);
  endfunction

  // Report the first ten failures in full; count the rest quietly
  function automatic void note_failure(string what);
    failures++;
    if (failures <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
  endfunction

  function automatic void clear_tracker();
    full_layout = 1'b0;
    err_hold    = 1'b0;
    frame_pos   = '0;
    sum_run     = '0;
    len_seen    = '0;
    sum_high    = '0;
    foreach (payload_copy[i]) payload_copy[i] = 8'h00;
  endfunction

  // Big-endian word from the store; bytes past its end read as zero
  function automatic logic [15:0] stored_word(int off);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (off < sfp_pkg::PayloadBytes) ? payload_copy[off] : 8'h00;
    lo = (off + 1 < sfp_pkg::PayloadBytes) ? payload_copy[off + 1] : 8'h00;
    return {hi, lo};
  endfunction

  // Value of word id under the current layout
  function automatic logic [15:0] layout_value(int id);
    int off;
    off = -1;
    if (full_layout) begin
      if (id <= 12) begin
        off = 2 * id;
      end else begin
        case (id)
          13:      off = 27;
          14:      off = 30;
          15:      off = 32;
          default: off = 34;
        endcase
      end
    end else begin
      case (id)
        1:       off = 0;
        12:      off = 2;
        13:      off = 5;
        14:      off = 8;
        15:      off = 10;
        16:      off = 12;
        default: off = -1;
      endcase
    end
    return (off < 0) ? 16'h0000 : stored_word(off);
  endfunction

  // Raise the sticky error and queue its single result
  function automatic void flag_error(sfp_pkg::err_code_t code);
    frame_result_t r;
    err_hold  = 1'b1;
    frame_pos = '0;
    r = '{is_error: 1'b1, error_code: code, field_id: '0, value: 16'h0000, last: 1'b1};
    awaited_results.push_back(r);
    error_results++;
  endfunction

  function automatic void follow_request(op_t op, logic [7:0] b);
    frame_result_t r;
    int idx;
    if (op == OP_CLEAR) begin
      // clear keeps the store, sum and length; it drops the sticky error and restarts framing
      err_hold  = 1'b0;
      frame_pos = '0;
      live_items++;
      return;
    end
    if (err_hold) return;  // bytes under a sticky error are dropped
    live_items++;
    if (frame_pos == 6'd0) begin
      if (b != sfp_pkg::StartByte0) begin
        flag_error(sfp_pkg::ERR_FIRST);
        return;
      end
      sum_run = {8'h00, b};
    end else if (frame_pos == 6'd1) begin
      if (b != sfp_pkg::StartByte1) begin
        flag_error(sfp_pkg::ERR_SECOND);
        return;
      end
      sum_run = sum_run + 16'(b);
    end else if (frame_pos == 6'd2) begin
      sum_run  = sum_run + 16'(b);
      len_seen = {b, 8'h00};
    end else if (frame_pos == 6'd3) begin
      len_seen[7:0] = b;
      if (len_seen != sfp_pkg::LenShort && len_seen != sfp_pkg::LenMid &&
          len_seen != sfp_pkg::LenLong) begin
        flag_error(sfp_pkg::ERR_LENGTH);
        return;
      end
      sum_run = sum_run + 16'(b);
    end else if (16'(frame_pos) == len_seen + 16'd2) begin
      sum_high = b;
    end else if (16'(frame_pos) == len_seen + 16'd3) begin
      frame_pos = '0;
      if ({sum_high, b} != sum_run) begin
        flag_error(sfp_pkg::ERR_CHECKSUM);
      end else begin
        for (int k = 0; k < sfp_pkg::NumWords; k++) begin
          // code field reads zero on measurement words
          r = '{is_error: 1'b0, error_code: sfp_pkg::ERR_FIRST,
                field_id: sfp_pkg::WordIdW'(k), value: layout_value(k),
                last: (k == sfp_pkg::NumWords - 1)};
          awaited_results.push_back(r);
        end
        good_frames++;
      end
      return;
    end else begin
      idx     = int'(frame_pos) - 4;
      sum_run = sum_run + 16'(b);
      if (idx < sfp_pkg::PayloadBytes) payload_copy[idx] = b;
    end
    frame_pos = frame_pos + 6'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte channel driver. Idle at random, then hold the request until it is
  // taken. Valid stays high across back-to-back requests.
  // ---------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic [7:0] b);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    total_items++;
    follow_request(op, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(OP_BYTE, b);
  endtask

  // Drop valid, wait for every awaited result, then let the burst logic drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write read_mode only with the parser idle
  task automatic write_read_mode(input logic full);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= full;
    @(posedge clk);
    cfg_we      <= 1'b0;
    full_layout = full;
    mode_writes++;
  endtask

  function automatic fill_t pick_fill();
    case ($urandom_range(9))
      0:       return FILL_ZERO;
      1:       return FILL_ONES;
      default: return FILL_RANDOM;
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(2))
      0:       return sfp_pkg::LenShort;
      1:       return sfp_pkg::LenMid;
      default: return sfp_pkg::LenLong;
    endcase
  endfunction

  // Whole frame with a correct checksum, or one bit of it flipped
  task automatic send_frame(input logic [15:0] len, input fill_t fill, input logic bad_sum);
    logic [15:0] sum;
    logic [7:0]  b;
    int          n;
    n   = int'(len) - 2;
    sum = 16'(sfp_pkg::StartByte0) + 16'(sfp_pkg::StartByte1) + 16'(len[15:8]) +
          16'(len[7:0]);
    send_byte(sfp_pkg::StartByte0);
    send_byte(sfp_pkg::StartByte1);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      sum = sum + 16'(b);
      send_byte(b);
    end
    if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(15));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  // A few stray bytes, then a clear to restart framing
  task automatic noise_then_clear();
    repeat ($urandom_range(3)) send_byte(8'($urandom));
    send_request(OP_CLEAR, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Length-20 frame straight after reset in full layout: the words past the
  // received payload read the cleared store as zero.
  task automatic test_short_frame_after_reset();
    write_read_mode(1'b1);
    send_frame(sfp_pkg::LenShort, FILL_ONES, 1'b0);
  endtask

  // Each framing error, the sticky drop of later bytes, and a clear mid-frame
  task automatic test_framing_errors();
    send_byte(8'h00);                 // bad first byte
    send_byte(sfp_pkg::StartByte0);   // dropped under the sticky error
    send_request(OP_CLEAR, 8'hFF);
    send_byte(sfp_pkg::StartByte0);
    send_byte(8'hFF);                 // bad second byte
    send_request(OP_CLEAR, 8'h00);
    send_byte(sfp_pkg::StartByte0);
    send_byte(sfp_pkg::StartByte1);
    send_byte(8'h01);
    send_byte(sfp_pkg::LenShort[7:0]); // length 0x0114
    send_request(OP_CLEAR, 8'h5A);
    send_byte(sfp_pkg::StartByte0);
    send_byte(sfp_pkg::StartByte1);
    send_byte(8'hFF);
    send_byte(8'hFF);                 // length 0xFFFF
    send_request(OP_CLEAR, 8'hA5);
    send_byte(sfp_pkg::StartByte0);
    send_byte(sfp_pkg::StartByte1);
    send_request(OP_CLEAR, 8'h00);    // restart framing mid-frame
    send_byte(sfp_pkg::StartByte1);   // now taken as a bad first byte
    send_request(OP_CLEAR, 8'h00);
  endtask

  // A good frame in general layout with no idling, then a bad checksum, then
  // a mix of good frames and broken sequences; read_mode moves between frames.
  task automatic test_random_traffic();
    int          goal;
    int          iter;
    int          cut;
    seq_kind_t   kind;
    logic [15:0] len;
    goal = total_items + RandomItems;
    iter = 0;
    while (total_items < goal) begin
      if (iter == 0) write_read_mode(1'b0);
      else if (iter == 2) write_read_mode(1'b1);
      else if ($urandom_range(99) < 40) write_read_mode(1'($urandom_range(1)));
      steady = (iter == 0);
      if (iter == 0) kind = SEQ_GOOD;
      else if (iter == 1) kind = SEQ_BAD_SUM;
      else if ($urandom_range(99) < 60) kind = SEQ_GOOD;
      else kind = seq_kind_t'($urandom_range(SEQ_BAD_SUM, SEQ_CUT));
      len = pick_length();
      case (kind)
        SEQ_GOOD: begin
          send_frame(len, pick_fill(), 1'b0);
        end
        SEQ_BAD_SUM: begin
          send_frame(len, pick_fill(), 1'b1);
          noise_then_clear();
        end
        SEQ_BAD_START: begin
          send_byte(8'($urandom));
          noise_then_clear();
        end
        SEQ_BAD_SECOND: begin
          send_byte(sfp_pkg::StartByte0);
          send_byte(8'($urandom));
          noise_then_clear();
        end
        SEQ_BAD_LENGTH: begin
          case ($urandom_range(2))
            0:       len = sfp_pkg::LenShort + 16'd1;
            1:       len = sfp_pkg::LenLong - 16'd1;
            default: len = 16'($urandom);
          endcase
          send_byte(sfp_pkg::StartByte0);
          send_byte(sfp_pkg::StartByte1);
          send_byte(len[15:8]);
          send_byte(len[7:0]);
          noise_then_clear();
        end
        default: begin
          // truncated frame abandoned by a clear
          send_byte(sfp_pkg::StartByte0);
          send_byte(sfp_pkg::StartByte1);
          send_byte(len[15:8]);
          send_byte(len[7:0]);
          cut = $urandom_range(int'(len) - 3);
          repeat (cut) send_byte(8'($urandom));
          noise_then_clear();
        end
      endcase
      steady = 1'b0;
      iter++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: stall at random, compare each accepted result with the
  // oldest awaited one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) sink_ready <= steady || ($urandom_range(99) >= IdlePct);

  always @(posedge clk) begin : check_results
    frame_result_t seen;
    frame_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = '{is_error: out_ch.is_error,
               error_code: sfp_pkg::err_code_t'(out_ch.error_code),
               field_id: out_ch.field_id, value: out_ch.value, last: out_ch.last};
      checked++;
      if (awaited_results.size() == 0) begin
        note_failure({"result with nothing awaited: ", show_result(seen)});
      end else begin
        want = awaited_results.pop_front();
        if (seen.is_error != want.is_error || seen.error_code != want.error_code ||
            seen.field_id != want.field_id || seen.value != want.value ||
            seen.last != want.last) begin
          note_failure({"expected ", show_result(want), " got ", show_result(seen)});
        end
      end
    end
  end

  // Watchdog: end the run if no request moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("[%0t] no request moved for %0d cycles, %0d results still awaited",
               $realtime, StallLimit, awaited_results.size());
      $display("sensor_frame_parser verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_BYTE;
    in_ch.rx_byte <= 8'h00;
    clear_tracker();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_frame_after_reset();
    test_framing_errors();
    test_random_traffic();
    settle();

    $display("%0d requests sent (%0d acted on), %0d good frames, %0d frame errors, %0d results checked",
             total_items, live_items, good_frames, error_results, checked);
    $display("read_mode written %0d times; good frames in both layouts, every error code",
             mode_writes);
    if (failures == 0) begin
      $display("sensor_frame_parser verification clean");
    end else begin
      $display("%0d failures", failures);
      $display("sensor_frame_parser verification failed");
    end
    $finish;
  end

endmodule
